FILE: rtl/core/cursor_motion_confine_tracker_macros.svh
// ----------------------------------------------------------------------------
// Cursor motion confine tracker assertion macros
// Shared concurrent assertion forms for the tracker checks.
// ----------------------------------------------------------------------------
`ifndef CURSOR_MOTION_CONFINE_TRACKER_MACROS_SVH
`define CURSOR_MOTION_CONFINE_TRACKER_MACROS_SVH

// Property checked at every clock edge once reset is released.
`define CMCT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cursor tracker check failed");

// Property checked at every clock edge, reset included.
`define CMCT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("cursor tracker check failed");

`endif

FILE: rtl/core/cmct_pkg.sv
// ----------------------------------------------------------------------------
// Cursor motion confine tracker package
// Beat types, configuration layout and shared arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmct_pkg;

    // Field widths fixed by the interface.
    localparam int DELTA_W = 12;
    localparam int SYS_W   = 12;
    localparam int POS_W   = 16;
    localparam int SPAN_W  = 24;
    localparam int MODE_W  = 3;
    localparam int SPEED_W = 16;
    localparam int INDEX_W = 3;

    // Scaled delta: 12-bit signed times 8.8 unsigned, fraction dropped.
    localparam int PROD_W  = DELTA_W + SPEED_W + 1;
    localparam int SCALE_W = PROD_W - 8;

    // Working width for sums of a position and a scaled delta.
    localparam int CALC_W  = 23;

    // Register reset values.
    localparam logic [SPAN_W-1:0]  CONTROL_X_RESET = SPAN_W'(319);
    localparam logic [SPAN_W-1:0]  CONTROL_Y_RESET = SPAN_W'(199);
    localparam logic [SPAN_W-1:0]  LIMIT_X_RESET   = SPAN_W'(4095);
    localparam logic [SPAN_W-1:0]  LIMIT_Y_RESET   = SPAN_W'(4095);
    localparam logic [MODE_W-1:0]  MODE_RESET      = MODE_W'(4);
    localparam logic [SPEED_W-1:0] SPEED_RESET     = SPEED_W'(256);

    // Mode bit positions.
    localparam int MODE_ENABLE  = 0;
    localparam int MODE_CONFINE = 1;
    localparam int MODE_IGNORE  = 2;

    // Configuration register indexes.
    typedef enum logic [INDEX_W-1:0] {
        CFG_CONTROL_X = 3'd0,
        CFG_CONTROL_Y = 3'd1,
        CFG_LIMIT_X   = 3'd2,
        CFG_LIMIT_Y   = 3'd3,
        CFG_MODE      = 3'd4,
        CFG_SPEED     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [SPAN_W-1:0]  control_x_span;
        logic [SPAN_W-1:0]  control_y_span;
        logic [SPAN_W-1:0]  limit_x_span;
        logic [SPAN_W-1:0]  limit_y_span;
        logic [MODE_W-1:0]  mode_bits;
        logic [SPEED_W-1:0] speed_factor;
    } cfg_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [SYS_W-1:0]          sys_x;
        logic [SYS_W-1:0]          sys_y;
        logic                      focus_lost;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] game_x;
        logic signed [POS_W-1:0] game_y;
        logic signed [POS_W-1:0] real_x_out;
        logic signed [POS_W-1:0] real_y_out;
        logic                    game_updated;
        logic                    warp;
    } out_item_t;

    // Beat held between the scaling stage and the tracking stage.
    typedef struct packed {
        logic signed [SCALE_W-1:0] scaled_x;
        logic signed [SCALE_W-1:0] scaled_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [SYS_W-1:0]          sys_x;
        logic [SYS_W-1:0]          sys_y;
        logic                      focus_lost;
    } stage_t;

    // Inclusive range test; an empty range contains nothing.
    function automatic logic in_span(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] lo,
        input logic signed [CALC_W-1:0] hi
    );
        in_span = (v >= lo) && (v <= hi);
    endfunction

    // Raise to the low edge first, then cap at the high edge.
    function automatic logic signed [CALC_W-1:0] clamp_span(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] lo,
        input logic signed [CALC_W-1:0] hi
    );
        logic signed [CALC_W-1:0] t;
        t = (v < lo) ? lo : v;
        clamp_span = (t > hi) ? hi : t;
    endfunction

    // Saturate to the signed position range.
    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [CALC_W-1:0] max_v;
        logic signed [CALC_W-1:0] min_v;
        max_v = CALC_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
        min_v = CALC_W'(signed'({1'b1, {(POS_W-1){1'b0}}}));
        if (v > max_v)
        begin
            sat_pos = max_v[POS_W-1:0];
        end
        else if (v < min_v)
        begin
            sat_pos = min_v[POS_W-1:0];
        end
        else
        begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cmct_cfg.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the rectangle, bound, mode and speed registers written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmct_cfg
    import cmct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [SPAN_W-1:0]  cfg_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTROL_X: cfg_next.control_x_span = cfg_data;
                CFG_CONTROL_Y: cfg_next.control_y_span = cfg_data;
                CFG_LIMIT_X:   cfg_next.limit_x_span   = cfg_data;
                CFG_LIMIT_Y:   cfg_next.limit_y_span   = cfg_data;
                CFG_MODE:      cfg_next.mode_bits      = cfg_data[MODE_W-1:0];
                CFG_SPEED:     cfg_next.speed_factor   = cfg_data[SPEED_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_x_span <= CONTROL_X_RESET;
            cfg_reg.control_y_span <= CONTROL_Y_RESET;
            cfg_reg.limit_x_span   <= LIMIT_X_RESET;
            cfg_reg.limit_y_span   <= LIMIT_Y_RESET;
            cfg_reg.mode_bits      <= MODE_RESET;
            cfg_reg.speed_factor   <= SPEED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cmct_front.sv
// ----------------------------------------------------------------------------
// Input stage with motion scaling
// Scales the deltas by the 8.8 speed factor and registers the beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmct_front
    import cmct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [SPEED_W-1:0] speed_factor,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  in_item_t                in_data,
    input  wire logic               advance,
    output logic                    stage_valid,
    output stage_t                  stage
);

    logic                      stage_valid_reg;
    logic                      stage_valid_next;
    stage_t                    stage_reg;
    stage_t                    stage_next;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [PROD_W-1:0]  adj_x;
    logic signed [PROD_W-1:0]  adj_y;
    logic                      take;

    // The stage takes a beat when empty or when its beat moves on.
    assign in_ready = !stage_valid_reg || advance;
    assign take     = in_valid && in_ready;

    // Multiply, then bias negatives so the shift truncates toward zero.
    always_comb
    begin
        prod_x = PROD_W'(in_data.delta_x) * PROD_W'(signed'({1'b0, speed_factor}));
        prod_y = PROD_W'(in_data.delta_y) * PROD_W'(signed'({1'b0, speed_factor}));
        adj_x  = prod_x + signed'(PROD_W'({8{prod_x[PROD_W-1]}}));
        adj_y  = prod_y + signed'(PROD_W'({8{prod_y[PROD_W-1]}}));
    end

    always_comb
    begin
        stage_next            = stage_reg;
        stage_valid_next      = stage_valid_reg;
        if (take)
        begin
            stage_next.scaled_x   = adj_x[PROD_W-1:8];
            stage_next.scaled_y   = adj_y[PROD_W-1:8];
            stage_next.delta_x    = in_data.delta_x;
            stage_next.delta_y    = in_data.delta_y;
            stage_next.sys_x      = in_data.sys_x;
            stage_next.sys_y      = in_data.sys_y;
            stage_next.focus_lost = in_data.focus_lost;
            stage_valid_next      = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cmct_track.sv
// ----------------------------------------------------------------------------
// Cursor tracking stage
// Updates the real and game cursors for one beat and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmct_track
    import cmct_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic stage_valid,
    input  stage_t    stage,
    output logic      advance,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    logic signed [POS_W-1:0]  real_x_reg;
    logic signed [POS_W-1:0]  real_y_reg;
    logic signed [POS_W-1:0]  game_x_reg;
    logic signed [POS_W-1:0]  game_y_reg;
    logic signed [POS_W-1:0]  real_x_next;
    logic signed [POS_W-1:0]  real_y_next;
    logic signed [POS_W-1:0]  game_x_next;
    logic signed [POS_W-1:0]  game_y_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_item_t                out_reg;
    out_item_t                out_next;

    logic signed [CALC_W-1:0] cx_lo;
    logic signed [CALC_W-1:0] cx_hi;
    logic signed [CALC_W-1:0] cy_lo;
    logic signed [CALC_W-1:0] cy_hi;
    logic signed [CALC_W-1:0] lx_lo;
    logic signed [CALC_W-1:0] lx_hi;
    logic signed [CALC_W-1:0] ly_lo;
    logic signed [CALC_W-1:0] ly_hi;
    logic signed [CALC_W-1:0] nx;
    logic signed [CALC_W-1:0] ny;
    logic signed [POS_W-1:0]  rx;
    logic signed [POS_W-1:0]  ry;
    logic signed [POS_W-1:0]  gx;
    logic signed [POS_W-1:0]  gy;
    logic                     updated;
    logic                     warp;
    logic                     enabled;
    logic                     confine;
    logic                     bounds_free;

    // Edge fields are unsigned COORD_BITS values, low edge above high edge.
    function automatic logic signed [CALC_W-1:0] lo_edge(input logic [SPAN_W-1:0] s);
        logic [COORD_BITS-1:0] e;
        e = COORD_BITS'(s >> COORD_BITS);
        lo_edge = signed'(CALC_W'(e));
    endfunction

    function automatic logic signed [CALC_W-1:0] hi_edge(input logic [SPAN_W-1:0] s);
        logic [COORD_BITS-1:0] e;
        e = s[COORD_BITS-1:0];
        hi_edge = signed'(CALC_W'(e));
    endfunction

    // A beat moves into the result register when that register is free.
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    assign enabled     = cfg.mode_bits[MODE_ENABLE];
    assign confine     = cfg.mode_bits[MODE_CONFINE];
    assign bounds_free = cfg.mode_bits[MODE_IGNORE];

    assign cx_lo = lo_edge(cfg.control_x_span);
    assign cx_hi = hi_edge(cfg.control_x_span);
    assign cy_lo = lo_edge(cfg.control_y_span);
    assign cy_hi = hi_edge(cfg.control_y_span);
    assign lx_lo = lo_edge(cfg.limit_x_span);
    assign lx_hi = hi_edge(cfg.limit_x_span);
    assign ly_lo = lo_edge(cfg.limit_y_span);
    assign ly_hi = hi_edge(cfg.limit_y_span);

    // Real cursor move, then the game cursor and its bound clamp.
    always_comb
    begin
        nx      = CALC_W'(real_x_reg) + CALC_W'(stage.scaled_x);
        ny      = CALC_W'(real_y_reg) + CALC_W'(stage.scaled_y);
        rx      = real_x_reg;
        ry      = real_y_reg;
        gx      = game_x_reg;
        gy      = game_y_reg;
        updated = 1'b0;
        warp    = 1'b0;

        if (!stage.focus_lost && enabled)
        begin
            priority if (in_span(nx, cx_lo, cx_hi) && in_span(ny, cy_lo, cy_hi))
            begin
                rx = sat_pos(nx);
                ry = sat_pos(ny);
            end
            else if (confine)
            begin
                rx = sat_pos(clamp_span(nx, cx_lo, cx_hi));
                ry = sat_pos(clamp_span(ny, cy_lo, cy_hi));
            end
            else
            begin
                rx = sat_pos(CALC_W'(real_x_reg) + CALC_W'(stage.delta_x));
                ry = sat_pos(CALC_W'(real_y_reg) + CALC_W'(stage.delta_y));
            end
            updated = in_span(CALC_W'(rx), cx_lo, cx_hi) && in_span(CALC_W'(ry), cy_lo, cy_hi);
        end
        else
        begin
            // Control off or focus away: follow the system cursor.
            rx      = signed'(POS_W'(stage.sys_x));
            ry      = signed'(POS_W'(stage.sys_y));
            updated = 1'b1;
        end

        if (updated)
        begin
            gx = rx;
            gy = ry;
            if (!bounds_free &&
                !(in_span(CALC_W'(gx), lx_lo, lx_hi) && in_span(CALC_W'(gy), ly_lo, ly_hi)))
            begin
                gx   = POS_W'(clamp_span(CALC_W'(gx), lx_lo, lx_hi));
                gy   = POS_W'(clamp_span(CALC_W'(gy), ly_lo, ly_hi));
                rx   = gx;
                ry   = gy;
                warp = 1'b1;
            end
        end
    end

    // State and result register updates.
    always_comb
    begin
        real_x_next    = real_x_reg;
        real_y_next    = real_y_reg;
        game_x_next    = game_x_reg;
        game_y_next    = game_y_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            real_x_next           = rx;
            real_y_next           = ry;
            game_x_next           = gx;
            game_y_next           = gy;
            out_next.game_x       = gx;
            out_next.game_y       = gy;
            out_next.real_x_out   = rx;
            out_next.real_y_out   = ry;
            out_next.game_updated = updated;
            out_next.warp         = warp;
            out_valid_next        = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_x_reg    <= '0;
            real_y_reg    <= '0;
            game_x_reg    <= '0;
            game_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            real_x_reg    <= real_x_next;
            real_y_reg    <= real_y_next;
            game_x_reg    <= game_x_next;
            game_y_reg    <= game_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cursor_motion_confine_tracker.sv
// ----------------------------------------------------------------------------
// Cursor motion confine tracker
// Tracks a real and a game cursor from polled mouse motion, one poll a beat.
//
// Usage: a poll beat (deltas, system position, focus flag) enters on the
// in_valid/in_ready channel and one result beat leaves on out_valid/out_ready.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Two register stages in all:
// the scaling multiplier ends in the input stage, and the cursor update ends
// in the result register. Throughput: one beat per cycle while the receiver
// does not stall; the real and game cursor registers close their update loop
// within the single tracking stage.
// Reset clears both cursors to zero, empties both stages and loads the
// register defaults. When the receiver stalls, the result register holds its
// beat and the input stage can still take one more beat; in_ready then drops
// until the result beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cursor_motion_confine_tracker
    import cmct_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [SPAN_W-1:0]  cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  in_item_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data
);

    cfg_t   cfg;
    logic   stage_valid;
    stage_t stage;
    logic   advance;

    cmct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .speed_factor (cfg.speed_factor),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .advance      (advance),
        .stage_valid  (stage_valid),
        .stage        (stage)
    );

    cmct_track #(
        .COORD_BITS (COORD_BITS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/cmct_checker.sv
// ----------------------------------------------------------------------------
// Cursor tracker port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cursor_motion_confine_tracker_macros.svh"

module cmct_checker
    import cmct_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input out_item_t out_data
);

    logic warp_ok;

    // A warped beat must be a refresh with both cursors in the same place.
    assign warp_ok = out_data.game_updated &&
                     (out_data.real_x_out == out_data.game_x) &&
                     (out_data.real_y_out == out_data.game_y);

    // A stalled result beat stays put.
    `CMCT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

    // A cycle spent in reset leaves no result offered at the next edge.
    `CMCT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

    // A warp only follows a game refresh and leaves both cursors together.
    `CMCT_ASSERT(a_warp_match, clk, rst_n, out_valid && out_data.warp |-> warp_ok)

    // With the result register empty the input side is always open.
    `CMCT_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)

endmodule

bind cursor_motion_confine_tracker cmct_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
